// ===== design/assert_macros.svh =====
// Assertion macros for the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/rcsfd_pkg.sv =====
// Types and constants for the RC serial frame decoder.
package rcsfd_pkg;

    localparam int FRAME_BYTES = 14;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int NUM_CH      = 6;
    localparam int CH_W        = 10;
    localparam int CHECK_POS   = 12;
    localparam int GAIN_CH     = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'h03;
    localparam logic [7:0] SYNC_SECOND = 8'h01;
    localparam logic [7:0] TAG_MASK    = 8'hFC;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Channel carried by each slot; slot 0 in the low bits.
    localparam logic [NUM_CH-1:0][2:0] SLOT_CHANNEL =
        {3'd4, 3'd0, 3'd3, 3'd2, 3'd5, 3'd1};

    localparam logic [15:0]     TIMEOUT_LIMIT_RST  = 16'd100;
    localparam logic [CH_W-1:0] AUTO_THRESHOLD_RST = 10'd288;
    localparam logic [7:0]      CHECK_BYTE_RST     = 8'h18;
    localparam logic [15:0]     TICK_MAX           = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_TIMEOUT_LIMIT  = 2'd0,
        REG_AUTO_THRESHOLD = 2'd1,
        REG_CHECK_BYTE     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic            frame_decoded;
        logic [CH_W-1:0] throttle_value;
        logic [CH_W-1:0] right_value;
        logic [CH_W-1:0] rear_value;
        logic [CH_W-1:0] rudder_value;
        logic [CH_W-1:0] gain_value;
        logic [CH_W-1:0] left_value;
        logic            auto_mode;
        logic            timed_out;
    } out_word_t;

    typedef logic [NUM_CH-1:0][CH_W-1:0] chan_vec_t;

    typedef struct packed {
        logic      pass;
        chan_vec_t chan;
        logic      auto_flag;
    } dec_result_t;

endpackage

// ===== design/rcsfd_frame_decode.sv =====
// Frame check and slot decode for one complete frame.
module rcsfd_frame_decode
    import rcsfd_pkg::*;
(
    input  logic [FRAME_BYTES-1:0][7:0] frame,
    input  logic [7:0]                  check_byte,
    input  logic [CH_W-1:0]             auto_threshold,
    input  chan_vec_t                   chan_cur,
    input  logic                        auto_cur,
    output dec_result_t                 result
);

    always_comb
    begin
        logic [7:0]      hi;
        logic [7:0]      lo;
        logic [2:0]      ch;
        logic [CH_W-1:0] v;
        result.pass      = (frame[CHECK_POS] == check_byte);
        result.chan      = chan_cur;
        result.auto_flag = auto_cur;
        // Slots are independent; each writes a distinct channel.
        for (int s = 0; s < NUM_CH; s++)
        begin
            hi = frame[2 * s];
            lo = frame[2 * s + 1];
            ch = SLOT_CHANNEL[s];
            v  = {hi[1:0], lo};
            if (result.pass && ((hi & TAG_MASK) == {3'b000, ch, 2'b00}))
            begin
                result.chan[ch] = v;
                if (ch == 3'(GAIN_CH))
                begin
                    result.auto_flag = (v <= auto_threshold);
                end
            end
        end
    end

endmodule

// ===== design/rc_serial_frame_decoder_core.sv =====
// Top level of the RC serial frame decoder: input stage, step logic, result stage.
// An accepted word waits in the input register until the result register can take it.
// Throughput: one word per cycle while results are taken; the input register and the
//   result register let a new word in while a finished result waits to be taken.
// Reset: control, config, channel values, tick count and auto flag clear (config to
//   defaults); the frame buffer is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module rc_serial_frame_decoder_core
    import rcsfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // input words
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    // result words
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data,
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic      s1_valid_reg, s1_valid_next;
    in_word_t  s1_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg, out_data_next;
    logic      s1_fire;
    logic      in_fire;

    // Step the held word when the result slot is free or being emptied.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !out_ready);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [15:0]     timeout_limit_reg;
    logic [CH_W-1:0] auto_threshold_reg;
    logic [7:0]      check_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg  <= TIMEOUT_LIMIT_RST;
            auto_threshold_reg <= AUTO_THRESHOLD_RST;
            check_byte_reg     <= CHECK_BYTE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TIMEOUT_LIMIT:  timeout_limit_reg  <= cfg_data;
                REG_AUTO_THRESHOLD: auto_threshold_reg <= cfg_data[CH_W-1:0];
                REG_CHECK_BYTE:     check_byte_reg     <= cfg_data[7:0];
                default:            ; // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    logic [7:0]       store_reg [FRAME_BYTES];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       prev_reg, prev_next;
    chan_vec_t        chan_reg, chan_next;
    logic [15:0]      tick_reg, tick_next;
    logic             auto_reg, auto_next;
    logic             store_we;
    logic             decode_now;

    logic [FRAME_BYTES-1:0][7:0] frame_bytes;
    dec_result_t                 dec;

    // Last frame byte comes straight from the word being stepped.
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame_bytes[i] = (i == FRAME_BYTES - 1) ? s1_data_reg.rx_byte : store_reg[i];
        end
    end

    rcsfd_frame_decode u_decode (
        .frame          (frame_bytes),
        .check_byte     (check_byte_reg),
        .auto_threshold (auto_threshold_reg),
        .chan_cur       (chan_reg),
        .auto_cur       (auto_reg),
        .result         (dec)
    );

    // One step of the decoder per fired word.
    always_comb
    begin
        logic b_is_sync;
        b_is_sync  = (s1_data_reg.rx_byte == SYNC_SECOND) && (prev_reg == SYNC_FIRST);
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        chan_next  = chan_reg;
        tick_next  = tick_reg;
        auto_next  = auto_reg;
        store_we   = 1'b0;
        decode_now = 1'b0;

        if (s1_fire)
        begin
            if (s1_data_reg.action == ACT_TICK)
            begin
                if (tick_reg != TICK_MAX)
                begin
                    tick_next = tick_reg + 16'd1;
                end
            end
            else
            begin
                if (b_is_sync)
                begin
                    pos_next = '0;
                end
                else if (pos_reg < POS_W'(FRAME_BYTES))
                begin
                    // Bytes past a full frame are dropped until the next sync.
                    store_we = 1'b1;
                    pos_next = pos_reg + POS_W'(1);
                    if (pos_reg == POS_W'(FRAME_BYTES - 1))
                    begin
                        decode_now = dec.pass;
                    end
                end
                prev_next = s1_data_reg.rx_byte;
            end
        end

        if (decode_now)
        begin
            chan_next = dec.chan;
            auto_next = dec.auto_flag;
            tick_next = '0;
        end
    end

    // Result word reflects state after this step.
    always_comb
    begin
        out_data_next.frame_decoded  = decode_now;
        out_data_next.throttle_value = chan_next[0];
        out_data_next.right_value    = chan_next[1];
        out_data_next.rear_value     = chan_next[2];
        out_data_next.rudder_value   = chan_next[3];
        out_data_next.gain_value     = chan_next[4];
        out_data_next.left_value     = chan_next[5];
        out_data_next.auto_mode      = auto_next;
        out_data_next.timed_out      = (tick_next > timeout_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            prev_reg      <= '0;
            chan_reg      <= '0;
            tick_reg      <= '0;
            auto_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            chan_reg      <= chan_next;
            tick_reg      <= tick_next;
            auto_reg      <= auto_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_fire)
        begin
            out_data_reg <= out_data_next;
        end
        if (store_we)
        begin
            store_reg[pos_reg[IDX_W-1:0]] <= s1_data_reg.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A good frame clears the tick count, so it can never report a timeout.
    `ASSERT_IMPLIES(a_decode_not_timed_out, clk, rst_n, out_valid && out_data.frame_decoded, !out_data.timed_out)
    // Write position never runs past the end of the buffer.
    `ASSERT_IMPLIES(a_pos_in_range, clk, rst_n, 1'b1, pos_reg <= POS_W'(FRAME_BYTES))
    // Backpressure only when both stages hold a word.
    `ASSERT_IMPLIES(a_ready_low_full, clk, rst_n, !in_ready, s1_valid_reg && out_valid_reg)
    // A stepped word always lands in the result stage.
    `ASSERT_NEXT(a_fire_gives_result, clk, rst_n, s1_fire, out_valid_reg)

endmodule

// ===== tb/sv/rcsfd_result_checker.sv =====
// Result checker for the RC serial frame decoder: mirrors the decoder and compares result words.
`timescale 1ns / 100ps

module rcsfd_result_checker
    import rcsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_word_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_word_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        end_of_test,
    output int          fail_count,
    output int          pending,
    output int          words_checked,
    output int          frames_seen,
    output int          timeout_words
);

    localparam int REPORT_LIMIT = 10;

    // mirrored registers
    logic [15:0]     limit_q;
    logic [CH_W-1:0] thresh_q;
    logic [7:0]      check_q;

    // mirrored decoder state
    logic [7:0]      frame_buf [FRAME_BYTES];
    int              fill_pos;
    logic [7:0]      last_byte;
    chan_vec_t       chan_vals;
    logic [15:0]     ticks;
    logic            auto_on;

    out_word_t       expected_words [$];
    bit              leftovers_counted;

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
        if (got !== want)
            flag_error($sformatf("word %0d %s: expected %0d, actual %0d",
                                 words_checked, name, want, got));
    endtask

    // Check byte, then update each slot whose tag matches its channel.
    function automatic logic apply_frame();
        int              s;
        logic [7:0]      hi;
        logic [7:0]      lo;
        logic [2:0]      ch;
        logic [CH_W-1:0] v;
        if (frame_buf[CHECK_POS] != check_q)
            return 1'b0;
        for (s = 0; s < NUM_CH; s++)
        begin
            hi = frame_buf[2 * s];
            lo = frame_buf[2 * s + 1];
            ch = SLOT_CHANNEL[s];
            if ((hi & TAG_MASK) == {3'b000, ch, 2'b00})
            begin
                v = {hi[1:0], lo};
                chan_vals[ch] = v;
                if (ch == GAIN_CH)
                    auto_on = (v <= thresh_q);
            end
        end
        ticks = '0;
        return 1'b1;
    endfunction

    function automatic out_word_t decode_step(input in_word_t w);
        out_word_t r;
        logic      decoded;
        decoded = 1'b0;
        if (w.action == ACT_TICK)
        begin
            if (ticks != TICK_MAX)
                ticks = ticks + 16'd1;
        end
        else
        begin
            if (w.rx_byte == SYNC_SECOND && last_byte == SYNC_FIRST)
                fill_pos = 0;
            else if (fill_pos < FRAME_BYTES)
            begin
                // once full, bytes are dropped until the next sync
                frame_buf[fill_pos] = w.rx_byte;
                fill_pos++;
                if (fill_pos == FRAME_BYTES)
                    decoded = apply_frame();
            end
            last_byte = w.rx_byte;
        end
        r.frame_decoded  = decoded;
        r.throttle_value = chan_vals[0];
        r.right_value    = chan_vals[1];
        r.rear_value     = chan_vals[2];
        r.rudder_value   = chan_vals[3];
        r.gain_value     = chan_vals[4];
        r.left_value     = chan_vals[5];
        r.auto_mode      = auto_on;
        r.timed_out      = (ticks > limit_q);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            limit_q   = TIMEOUT_LIMIT_RST;
            thresh_q  = AUTO_THRESHOLD_RST;
            check_q   = CHECK_BYTE_RST;
            fill_pos  = 0;
            last_byte = '0;
            chan_vals = '0;
            ticks     = '0;
            auto_on   = 1'b0;
            expected_words.delete();
        end
        else
        begin
            // results first: a word accepted now cannot answer this edge's input
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    flag_error("result word with no input word waiting");
                else
                begin
                    want = expected_words.pop_front();
                    check_field("frame_decoded", want.frame_decoded, out_data.frame_decoded);
                    check_field("throttle_value", want.throttle_value, out_data.throttle_value);
                    check_field("right_value", want.right_value, out_data.right_value);
                    check_field("rear_value", want.rear_value, out_data.rear_value);
                    check_field("rudder_value", want.rudder_value, out_data.rudder_value);
                    check_field("gain_value", want.gain_value, out_data.gain_value);
                    check_field("left_value", want.left_value, out_data.left_value);
                    check_field("auto_mode", want.auto_mode, out_data.auto_mode);
                    check_field("timed_out", want.timed_out, out_data.timed_out);
                    words_checked++;
                    if (want.frame_decoded)
                        frames_seen++;
                    if (want.timed_out)
                        timeout_words++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TIMEOUT_LIMIT:  limit_q  = cfg_data;
                    REG_AUTO_THRESHOLD: thresh_q = cfg_data[CH_W-1:0];
                    REG_CHECK_BYTE:     check_q  = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_words.push_back(decode_step(in_data));
            if (end_of_test && !leftovers_counted)
            begin
                leftovers_counted = 1'b1;
                if (expected_words.size() != 0)
                    flag_error($sformatf("%0d expected result words never arrived",
                                         expected_words.size()));
            end
        end
        pending = expected_words.size();
    end

endmodule

// ===== tb/sv/tb_rc_serial_frame_decoder_core.sv =====
// Testbench top for the RC serial frame decoder: stimulus, flow control and final verdict.
`timescale 1ns / 100ps

module tb_rc_serial_frame_decoder_core;
    import rcsfd_pkg::*;

    // Index past the register list; writes to it must be dropped.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int MAX_GAP      = 18;   // longest idle/stall drawn per word
    localparam int PHASE_ITEMS  = 300;  // counted words per random phase
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_LEAD    = 20;   // cycles into phase 0 before the sink stops
    localparam int HOLD_CYCLES  = 400;  // length of the long sink hold-off
    localparam int DRAIN_CYCLES = 8;    // settle time after the last result
    localparam int BURST_TICKS  = 8;    // back-to-back ticks across a small limit
    localparam int CH_MAX       = (1 << CH_W) - 1;

    typedef enum {IDLE_RANDOM, IDLE_NONE} idle_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_word_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_TIMEOUT_LIMIT;
    logic [15:0] cfg_data = '0;
    logic        end_of_test = 1'b0;

    int fail_count;
    int pending;
    int words_checked;
    int frames_seen;
    int timeout_words;

    // Stimulus bookkeeping; shadows of the programmed registers steer the frame builder.
    int              sent_count;
    int              ignored_count;
    int              config_count;
    logic [CH_W-1:0] thr_shadow = AUTO_THRESHOLD_RST;
    logic [7:0]      chk_shadow = CHECK_BYTE_RST;
    idle_mode_t      idle_mode = IDLE_RANDOM;
    bit              hold_go = 1'b0;
    logic            sink_hold = 1'b0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rc_serial_frame_decoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Watches all three channels, predicts every result word and counts failures.
    rcsfd_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .end_of_test   (end_of_test),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .frames_seen   (frames_seen),
        .timeout_words (timeout_words)
    );

    // Per-word idle draw shared by both sides; IDLE_NONE gives back-to-back stretches.
    function automatic int draw_gap();
        if (idle_mode == IDLE_NONE)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Slot high byte: channel tag in bits 4:2, value bits 9:8 below it.
    function automatic logic [7:0] slot_hi(input logic [2:0] ch, input logic [CH_W-1:0] v);
        return {3'b000, ch, v[9:8]};
    endfunction

    // Offer one input word. Called at a rising edge; returns at the edge that accepted it.
    // With no gap, valid simply stays high with the next payload.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_word_t w;
        w.action  = ACT_BYTE;
        w.rx_byte = b;
        send_word(w);
    endtask

    // Tick words carry a random byte, which the block must ignore.
    task automatic send_tick();
        in_word_t w;
        w.action  = ACT_TICK;
        w.rx_byte = 8'($urandom);
        send_word(w);
    endtask

    // One register write; valid stays high across back-to-back writes.
    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Program all registers. Upper data bits of the narrow registers are random,
    // so the write must truncate them. Only called while the block is idle.
    task automatic set_config(input logic [15:0] limit, input logic [CH_W-1:0] thr,
                              input logic [7:0] chk, input bit touch_spare);
        logic [15:0] r;
        r = 16'($urandom);
        put_reg(REG_TIMEOUT_LIMIT, limit);
        put_reg(REG_AUTO_THRESHOLD, {r[15:CH_W], thr});
        put_reg(REG_CHECK_BYTE, {r[7:0], chk});
        if (touch_spare)
            put_reg(REG_SPARE, r ^ 16'hA5C3);
        cfg_valid <= 1'b0;
        thr_shadow = thr;
        chk_shadow = chk;
        config_count++;
    endtask

    // Stop offering input and wait until every predicted result has been taken.
    // Every word yields a result, so an empty queue means the block is idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Mostly well-formed frames: sync mark, matching tags, the expected check byte,
    // gain values clustered around the threshold. The rest are broken on purpose:
    // no sync, wrong tags, wrong check byte, truncated frames (resynced by the next
    // mark), ticks scattered inside the frame, and trailing bytes after a full frame.
    task automatic send_frame();
        logic [7:0]      fb [FRAME_BYTES];
        logic [CH_W-1:0] v;
        logic [2:0]      ch;
        int              s;
        int              k;
        int              t;
        int              cut;
        int              junk;
        for (s = 0; s < NUM_CH; s++)
        begin
            ch = SLOT_CHANNEL[s];
            if (ch == GAIN_CH && $urandom_range(0, 1) == 1)
            begin
                t = int'(thr_shadow) + int'($urandom_range(0, 4)) - 2;
                if (t < 0)
                    t = 0;
                if (t > CH_MAX)
                    t = CH_MAX;
                v = CH_W'(t);
            end
            else
                v = CH_W'($urandom);
            if ($urandom_range(0, 7) != 0)
                fb[2 * s] = slot_hi(ch, v);
            else
                fb[2 * s] = 8'($urandom);
            fb[2 * s + 1] = v[7:0];
        end
        if ($urandom_range(0, 7) != 0)
            fb[CHECK_POS] = chk_shadow;
        else
            fb[CHECK_POS] = 8'($urandom);
        fb[FRAME_BYTES-1] = 8'($urandom);

        if ($urandom_range(0, 7) != 0)
        begin
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAME_BYTES - 1) : FRAME_BYTES;
        for (k = 0; k < cut; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_tick();
            send_byte(fb[k]);
        end
        // bytes past a full frame are dropped until the next sync
        junk = (cut == FRAME_BYTES && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (junk)
        begin
            send_byte(8'($urandom));
            ignored_count++;
        end
    endtask

    // Result side: random stall before each word, plus the long hold-off below.
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0 || sink_hold)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (sink_hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Long receiver hold-off early in the random part; the sender keeps offering,
    // so the result stage fills and in_ready must drop.
    initial
    begin : hold_off
        wait (hold_go);
        repeat (HOLD_LEAD) @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin : watchdog
        #20ms;
        $display("Timeout: stimulus or results stopped making progress");
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]      fb [FRAME_BYTES];
        logic [CH_W-1:0] corner [NUM_CH];
        logic [15:0]     lim;
        logic [CH_W-1:0] thr;
        logic [7:0]      chk;
        bit              spare;
        in_word_t        w;
        int              s;
        int              p;
        int              n;
        int              pick;
        int              target;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part, reset register values ----
        // Frame straight after reset with no sync: position starts at 0.
        // Values hit both ends of the 10-bit range; gain sits exactly on the
        // default threshold, so auto mode must come on.
        corner = '{10'h3FF, 10'h000, 10'h300, 10'h0FF, 10'h3FF, AUTO_THRESHOLD_RST};
        for (s = 0; s < NUM_CH; s++)
        begin
            fb[2 * s]     = slot_hi(SLOT_CHANNEL[s], corner[s]);
            fb[2 * s + 1] = corner[s][7:0];
        end
        fb[CHECK_POS]     = CHECK_BYTE_RST;
        fb[FRAME_BYTES-1] = 8'hFF;
        for (s = 0; s < FRAME_BYTES; s++)
            send_byte(fb[s]);
        send_byte(8'hFF);          // past a full frame: dropped
        send_tick();               // tick leaves the previous byte alone
        send_byte(SYNC_FIRST);
        send_tick();               // a tick between the two mark bytes keeps the mark
        send_byte(SYNC_SECOND);
        send_byte(8'h00);          // short partial frame, resynced later
        send_byte(8'hFF);
        send_byte(8'h80);

        // ---- Back-to-back ticks walking across a small limit ----
        wait_idle();
        set_config(16'd2, CH_W'(CH_MAX), 8'hFF, 1'b1);
        idle_mode = IDLE_NONE;
        repeat (BURST_TICKS)
            send_tick();

        // ---- Random phases, one register setting each ----
        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            spare = 1'b0;
            case (p)
                0:
                begin
                    lim = 16'd3;
                    thr = CH_W'(CH_MAX);
                    chk = CHECK_BYTE_RST;
                    spare = 1'b1;
                end
                1:
                begin
                    lim = 16'd0;
                    thr = '0;
                    chk = 8'h00;
                end
                2:
                begin
                    lim = 16'd65534;
                    thr = CH_W'($urandom);
                    chk = 8'hFF;
                end
                3:
                begin
                    lim = 16'($urandom_range(0, 30));
                    thr = CH_W'($urandom);
                    chk = 8'($urandom);
                end
                4:
                begin
                    lim = 16'd10;
                    thr = AUTO_THRESHOLD_RST;
                    chk = CHECK_BYTE_RST;
                    spare = 1'b1;
                end
                default:
                begin
                    lim = 16'($urandom_range(0, 65534));
                    thr = CH_W'($urandom);
                    chk = 8'($urandom);
                end
            endcase
            set_config(lim, thr, chk, spare);
            idle_mode = IDLE_RANDOM;
            if (p == 0)
                hold_go = 1'b1;

            target = sent_count - ignored_count + PHASE_ITEMS;
            while (sent_count - ignored_count < target)
            begin
                // occasional back-to-back stretches on both sides
                if ($urandom_range(0, 19) == 0)
                    idle_mode = ($urandom_range(0, 3) == 0) ? IDLE_NONE : IDLE_RANDOM;
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    send_frame();
                else if (pick < 9)
                begin
                    // tick bursts walk the counter across small limits
                    n = $urandom_range(1, 24);
                    repeat (n)
                        send_tick();
                end
                else
                begin
                    // raw noise: random action and byte
                    n = $urandom_range(1, 8);
                    repeat (n)
                    begin
                        w.action  = 1'($urandom);
                        w.rx_byte = 8'($urandom);
                        send_word(w);
                    end
                end
            end
        end

        // ---- Drain and verdict ----
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_of_test <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        $display("Summary: %0d input words, %0d results checked, %0d frames decoded",
                 sent_count, words_checked, frames_seen);
        $display("Summary: %0d trailing drops, %0d register settings, %0d timed-out results",
                 ignored_count, config_count, timeout_words);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
